/* sv/ljpe_pkg.sv */
// ----------------------------------------------------------------------------
// ljpe_pkg: shared types and constants of the Lennard-Jones pair energy block
// Mode and word-select codes, the class of a pair request and the request
// record that travels from the front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package ljpe_pkg;

	localparam int DATA_W      = 32;
	localparam int PAIR_TYPE_W = 4;
	localparam int ENERGY_W    = 48;
	localparam int PROD_W      = 64;

	localparam logic [1:0] MODE_WCA    = 2'd0;
	localparam logic [1:0] MODE_LJ     = 2'd1;
	localparam logic [1:0] MODE_LJ_ALT = 2'd2;
	localparam logic [1:0] MODE_LOAD   = 2'd3;

	localparam logic [1:0] WSEL_CUTOFF  = 2'd0;
	localparam logic [1:0] WSEL_SIGMA   = 2'd1;
	localparam logic [1:0] WSEL_EPSILON = 2'd2;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
	localparam logic [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CLS_EVAL,
		CLS_BEYOND,
		CLS_ZERO
	} pair_class_t;

	typedef struct packed {
		pair_class_t       cls;
		logic              wca;
		logic [DATA_W-1:0] dist_sq;
		logic [DATA_W-1:0] sigma_sq;
		logic [DATA_W-1:0] epsilon;
	} pair_req_t;

endpackage

/* sv/ljpe_ram.sv */
// ----------------------------------------------------------------------------
// ljpe_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ljpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/ljpe_front.sv */
// ----------------------------------------------------------------------------
// ljpe_front: request intake, parameter tables and pair classification
// Writes table words for load requests, reads the three tables for pair
// requests and sorts each pair into beyond cutoff, zero distance or evaluate.
// ----------------------------------------------------------------------------
module ljpe_front
	import ljpe_pkg::*;
#(
	parameter int PAIR_TYPES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             mode,
	input  logic [DATA_W-1:0]      distance_squared,
	input  logic [PAIR_TYPE_W-1:0] pair_type,
	input  logic                   table_set,
	input  logic [1:0]             word_select,
	input  logic [DATA_W-1:0]      load_value,
	output logic                   req_valid,
	input  logic                   req_ready,
	output pair_req_t              req
);

	localparam int TABLE_DEPTH = 2 * PAIR_TYPES;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int TW          = (PAIR_TYPES > 1) ? $clog2(PAIR_TYPES) : 1;
	localparam int TYPE_CODES  = 2 ** PAIR_TYPE_W;

	logic [TW-1:0]     type_mod [TYPE_CODES];
	logic              is_load;
	logic              accept;
	logic              set_sel;
	logic [AW-1:0]     tbl_addr;
	logic              rd_en;
	logic              we_cut;
	logic              we_sig;
	logic              we_eps;
	logic [DATA_W-1:0] cut_rd;
	logic [DATA_W-1:0] sig_rd;
	logic [DATA_W-1:0] eps_rd;
	logic              fv_s1;
	logic              wca_s1;
	logic [DATA_W-1:0] d2_s1;

	// Pair type folded into the configured number of types.
	for (genvar i = 0; i < TYPE_CODES; i++) begin : g_type_mod
		assign type_mod[i] = TW'(i % PAIR_TYPES);
	end

	assign is_load  = (mode == MODE_LOAD);
	assign in_ready = !fv_s1 || req_ready;
	assign accept   = in_valid && in_ready;
	assign set_sel  = is_load ? table_set : (mode == MODE_LJ_ALT);
	assign tbl_addr = AW'(type_mod[pair_type]) + (set_sel ? AW'(PAIR_TYPES) : AW'(0));

	assign rd_en  = accept && !is_load;
	assign we_cut = accept && is_load && (word_select == WSEL_CUTOFF);
	assign we_sig = accept && is_load && (word_select == WSEL_SIGMA);
	assign we_eps = accept && is_load && (word_select == WSEL_EPSILON);

	ljpe_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_cutoff_ram (
		.clk   (clk),
		.we    (we_cut),
		.waddr (tbl_addr),
		.wdata (load_value),
		.re    (rd_en),
		.raddr (tbl_addr),
		.rdata (cut_rd)
	);

	ljpe_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_sigma_ram (
		.clk   (clk),
		.we    (we_sig),
		.waddr (tbl_addr),
		.wdata (load_value),
		.re    (rd_en),
		.raddr (tbl_addr),
		.rdata (sig_rd)
	);

	ljpe_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_epsilon_ram (
		.clk   (clk),
		.we    (we_eps),
		.waddr (tbl_addr),
		.wdata (load_value),
		.re    (rd_en),
		.raddr (tbl_addr),
		.rdata (eps_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s1 <= 1'b0;
		end else if (in_ready) begin
			fv_s1 <= in_valid && !is_load;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			wca_s1 <= (mode == MODE_WCA);
			d2_s1  <= distance_squared;
		end
	end

	always_comb begin
		req.wca      = wca_s1;
		req.dist_sq  = d2_s1;
		req.sigma_sq = sig_rd;
		req.epsilon  = eps_rd;
		if (d2_s1 > cut_rd) begin
			req.cls = CLS_BEYOND;
		end else if (d2_s1 == '0) begin
			req.cls = CLS_ZERO;
		end else begin
			req.cls = CLS_EVAL;
		end
	end

	assign req_valid = fv_s1;

endmodule

/* sv/ljpe_queue.sv */
// ----------------------------------------------------------------------------
// ljpe_queue: small request queue between front end and back end
// Lets the front end keep accepting while the back end is stalled.
// ----------------------------------------------------------------------------
module ljpe_queue
	import ljpe_pkg::*;
#(
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  pair_req_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output pair_req_t pop_data
);

	pair_req_t     slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on a lone push");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not shrink on a lone pop");

endmodule

/* sv/ljpe_div.sv */
// ----------------------------------------------------------------------------
// ljpe_div: pipelined restoring divider, one quotient bit per stage
// Computes floor((hi << FRAC_BITS) / divisor) and carries a tag alongside.
// ----------------------------------------------------------------------------
module ljpe_div
	import ljpe_pkg::*;
#(
	parameter int FRAC_BITS = 24,
	parameter int TAG_W = 1,
	localparam int QW = DATA_W + FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DATA_W-1:0] dividend_hi,
	input  logic [DATA_W-1:0] divisor,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_valid,
	output logic [QW-1:0]     quotient,
	output logic [TAG_W-1:0]  out_tag
);

	logic [DATA_W-1:0] rem_s  [QW];
	logic [QW-1:0]     dq_s   [QW];
	logic [DATA_W-1:0] dvs_s  [QW];
	logic [TAG_W-1:0]  tag_s  [QW];
	logic [QW-1:0]     vld_s;

	logic [DATA_W-1:0] rem_in [QW];
	logic [QW-1:0]     dq_in  [QW];
	logic [DATA_W-1:0] dvs_in [QW];
	logic [TAG_W-1:0]  tag_in [QW];
	logic [QW-1:0]     vld_in;
	logic [DATA_W:0]   trial  [QW];
	logic [QW-1:0]     ge;
	logic [DATA_W-1:0] rem_nx [QW];
	logic [QW-1:0]     dq_nx  [QW];

	// Each stage shifts one dividend bit into the partial remainder and
	// shifts one quotient bit into the low end of the same word.
	always_comb begin
		rem_in[0] = '0;
		dq_in[0]  = {dividend_hi, {FRAC_BITS{1'b0}}};
		dvs_in[0] = divisor;
		tag_in[0] = in_tag;
		vld_in[0] = in_valid;
		for (int k = 1; k < QW; k++) begin
			rem_in[k] = rem_s[k-1];
			dq_in[k]  = dq_s[k-1];
			dvs_in[k] = dvs_s[k-1];
			tag_in[k] = tag_s[k-1];
			vld_in[k] = vld_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			trial[k]  = {rem_in[k], dq_in[k][QW-1]};
			ge[k]     = (trial[k] >= {1'b0, dvs_in[k]});
			rem_nx[k] = ge[k] ? DATA_W'(trial[k] - {1'b0, dvs_in[k]}) : trial[k][DATA_W-1:0];
			dq_nx[k]  = {dq_in[k][QW-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= rem_nx[k];
				dq_s[k]  <= dq_nx[k];
				dvs_s[k] <= dvs_in[k];
				tag_s[k] <= tag_in[k];
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quotient  = dq_s[QW-1];
	assign out_tag   = tag_s[QW-1];

endmodule

/* sv/ljpe_mul.sv */
// ----------------------------------------------------------------------------
// ljpe_mul: pipelined 64x64 fixed-point multiplier
// Four 32x32 partial products, a middle sum, then the full product; the
// result is the product shifted right by FRAC_BITS, with an overflow flag
// when it does not fit in 64 bits. A tag travels alongside.
// ----------------------------------------------------------------------------
module ljpe_mul
	import ljpe_pkg::*;
#(
	parameter int FRAC_BITS = 24,
	parameter int TAG_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [PROD_W-1:0] a,
	input  logic [PROD_W-1:0] b,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_valid,
	output logic [PROD_W-1:0] product,
	output logic              overflow,
	output logic [TAG_W-1:0]  out_tag
);

	localparam int HALF_W = PROD_W / 2;
	localparam int FULL_W = 2 * PROD_W;

	logic [PROD_W-1:0] p00_s1;
	logic [PROD_W-1:0] p01_s1;
	logic [PROD_W-1:0] p10_s1;
	logic [PROD_W-1:0] p11_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [PROD_W:0]   mid_s2;
	logic [PROD_W-1:0] lo_s2;
	logic [PROD_W-1:0] hi_s2;
	logic [TAG_W-1:0]  tag_s2;
	logic [FULL_W-1:0] full_s3;
	logic [TAG_W-1:0]  tag_s3;
	logic [2:0]        vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= a[HALF_W-1:0] * b[HALF_W-1:0];
			p01_s1  <= a[HALF_W-1:0] * b[PROD_W-1:HALF_W];
			p10_s1  <= a[PROD_W-1:HALF_W] * b[HALF_W-1:0];
			p11_s1  <= a[PROD_W-1:HALF_W] * b[PROD_W-1:HALF_W];
			tag_s1  <= in_tag;
			mid_s2  <= {1'b0, p01_s1} + {1'b0, p10_s1};
			lo_s2   <= p00_s1;
			hi_s2   <= p11_s1;
			tag_s2  <= tag_s1;
			full_s3 <= {hi_s2, lo_s2} + {{(HALF_W-1){1'b0}}, mid_s2, {HALF_W{1'b0}}};
			tag_s3  <= tag_s2;
		end
	end

	assign out_valid = vld_s[2];
	assign product   = full_s3[FRAC_BITS +: PROD_W];
	assign overflow  = |full_s3[FULL_W-1:PROD_W+FRAC_BITS];
	assign out_tag   = tag_s3;

endmodule

/* sv/ljpe_back.sv */
// ----------------------------------------------------------------------------
// ljpe_back: arithmetic back end of the pair energy evaluator
// Divider, power chain s^2, s^3, s^6, the difference term, the epsilon
// product and the final clip, ending in the output register.
// ----------------------------------------------------------------------------
module ljpe_back
	import ljpe_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  pair_req_t                  req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ENERGY_W-1:0] energy,
	output logic                       saturated
);

	localparam int QW = DATA_W + FRAC_BITS;
	localparam logic [PROD_W:0] WCA_ONE = (PROD_W + 1)'(1) << FRAC_BITS;

	typedef struct packed {
		pair_class_t       cls;
		logic              wca;
		logic [DATA_W-1:0] eps;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [PROD_W-1:0] q;
	} m1_tag_t;

	typedef struct packed {
		side_t side;
		logic  ovf;
	} m2_tag_t;

	typedef struct packed {
		side_t             side;
		logic              ovf;
		logic [PROD_W-1:0] s3;
	} m3_tag_t;

	typedef struct packed {
		pair_class_t cls;
		logic        ovf;
		logic        eps_zero;
		logic        neg;
	} m4_tag_t;

	logic              adv;
	side_t             div_tag_in;
	side_t             div_tag_out;
	logic              div_vld;
	logic [QW-1:0]     quo;

	m1_tag_t           m1_tag_in;
	m1_tag_t           m1_tag_out;
	logic              m1_vld;
	logic [PROD_W-1:0] s2;
	logic              s2_ovf;

	m2_tag_t           m2_tag_in;
	m2_tag_t           m2_tag_out;
	logic              m2_vld;
	logic [PROD_W-1:0] s3;
	logic              s3_ovf;

	m3_tag_t           m3_tag_in;
	m3_tag_t           m3_tag_out;
	logic              m3_vld;
	logic [PROD_W-1:0] s6;
	logic              s6_ovf;

	logic              vld_s1;
	side_t             side_s1;
	logic              ovf_s1;
	logic [PROD_W:0]   pos_s1;
	logic [PROD_W-1:0] dbl_s1;

	logic              vld_s2;
	m4_tag_t           tag_s2;
	logic [PROD_W-1:0] mag_s2;
	logic [DATA_W-1:0] eps_s2;

	logic              neg_d;
	m4_tag_t           m4_tag_out;
	logic              m4_vld;
	logic [PROD_W-1:0] prod;
	logic              prod_ovf;

	logic              pos_clip;
	logic              neg_clip;
	logic [ENERGY_W-1:0] energy_d;
	logic              sat_d;

	logic              out_valid_q;
	logic [ENERGY_W-1:0] energy_q;
	logic              saturated_q;

	// The whole back end moves together; it freezes only while a finished
	// result waits in the output register.
	assign adv       = !out_valid_q || out_ready;
	assign req_ready = adv;

	assign div_tag_in.cls = req.cls;
	assign div_tag_in.wca = req.wca;
	assign div_tag_in.eps = req.epsilon;

	ljpe_div #(.FRAC_BITS(FRAC_BITS), .TAG_W($bits(side_t))) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (req_valid),
		.dividend_hi (req.sigma_sq),
		.divisor     (req.dist_sq),
		.in_tag      (div_tag_in),
		.out_valid   (div_vld),
		.quotient    (quo),
		.out_tag     (div_tag_out)
	);

	// s^2 = q * q
	assign m1_tag_in.side = div_tag_out;
	assign m1_tag_in.q    = PROD_W'(quo);

	ljpe_mul #(.FRAC_BITS(FRAC_BITS), .TAG_W($bits(m1_tag_t))) u_mul_s2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (div_vld),
		.a         (m1_tag_in.q),
		.b         (m1_tag_in.q),
		.in_tag    (m1_tag_in),
		.out_valid (m1_vld),
		.product   (s2),
		.overflow  (s2_ovf),
		.out_tag   (m1_tag_out)
	);

	// s^3 = s^2 * q
	assign m2_tag_in.side = m1_tag_out.side;
	assign m2_tag_in.ovf  = s2_ovf;

	ljpe_mul #(.FRAC_BITS(FRAC_BITS), .TAG_W($bits(m2_tag_t))) u_mul_s3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (m1_vld),
		.a         (s2),
		.b         (m1_tag_out.q),
		.in_tag    (m2_tag_in),
		.out_valid (m2_vld),
		.product   (s3),
		.overflow  (s3_ovf),
		.out_tag   (m2_tag_out)
	);

	// s^6 = s^3 * s^3; the doubled s^3 must also fit in 64 bits.
	assign m3_tag_in.side = m2_tag_out.side;
	assign m3_tag_in.ovf  = m2_tag_out.ovf || s3_ovf || s3[PROD_W-1];
	assign m3_tag_in.s3   = s3;

	ljpe_mul #(.FRAC_BITS(FRAC_BITS), .TAG_W($bits(m3_tag_t))) u_mul_s6 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (m2_vld),
		.a         (s3),
		.b         (s3),
		.in_tag    (m3_tag_in),
		.out_valid (m3_vld),
		.product   (s6),
		.overflow  (s6_ovf),
		.out_tag   (m3_tag_out)
	);

	// Repulsive term (plus one in WCA mode, with carry kept) and 2*s^3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= m3_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= m3_tag_out.side;
			ovf_s1  <= m3_tag_out.ovf || s6_ovf;
			pos_s1  <= {1'b0, s6} + (m3_tag_out.side.wca ? WCA_ONE : '0);
			dbl_s1  <= {m3_tag_out.s3[PROD_W-2:0], 1'b0};
		end
	end

	// Magnitude and sign of the difference.
	assign neg_d = (pos_s1[PROD_W-1:0] < dbl_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2.cls      <= side_s1.cls;
			tag_s2.ovf      <= ovf_s1 || pos_s1[PROD_W];
			tag_s2.eps_zero <= (side_s1.eps == '0);
			tag_s2.neg      <= neg_d;
			mag_s2          <= neg_d ? (dbl_s1 - pos_s1[PROD_W-1:0])
			                         : (pos_s1[PROD_W-1:0] - dbl_s1);
			eps_s2          <= side_s1.eps;
		end
	end

	// Energy magnitude = eps * |difference|.
	ljpe_mul #(.FRAC_BITS(FRAC_BITS), .TAG_W($bits(m4_tag_t))) u_mul_eps (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.a         ({{(PROD_W-DATA_W){1'b0}}, eps_s2}),
		.b         (mag_s2),
		.in_tag    (tag_s2),
		.out_valid (m4_vld),
		.product   (prod),
		.overflow  (prod_ovf),
		.out_tag   (m4_tag_out)
	);

	// Sign, clipping to 48 bits and the special classes.
	always_comb begin
		pos_clip = prod_ovf || (|prod[PROD_W-1:ENERGY_W-1]);
		neg_clip = prod_ovf || (|prod[PROD_W-1:ENERGY_W])
		           || (prod[ENERGY_W-1] && (|prod[ENERGY_W-2:0]));
		energy_d = '0;
		sat_d    = 1'b0;
		case (m4_tag_out.cls)
			CLS_EVAL: begin
				if (m4_tag_out.ovf) begin
					if (!m4_tag_out.eps_zero) begin
						energy_d = ENERGY_MAX;
						sat_d    = 1'b1;
					end
				end else if (!m4_tag_out.neg) begin
					if (pos_clip) begin
						energy_d = ENERGY_MAX;
						sat_d    = 1'b1;
					end else begin
						energy_d = prod[ENERGY_W-1:0];
					end
				end else if (neg_clip) begin
					energy_d = ENERGY_MIN;
					sat_d    = 1'b1;
				end else begin
					energy_d = ~prod[ENERGY_W-1:0] + 1'b1;
				end
			end
			CLS_BEYOND: begin
				energy_d = '0;
				sat_d    = 1'b0;
			end
			CLS_ZERO: begin
				energy_d = ENERGY_MAX;
				sat_d    = 1'b1;
			end
			default: begin
				energy_d = '0;
				sat_d    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= m4_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			energy_q    <= energy_d;
			saturated_q <= sat_d;
		end
	end

	assign out_valid = out_valid_q;
	assign energy    = signed'(energy_q);
	assign saturated = saturated_q;

	a_beyond_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && m4_vld && m4_tag_out.cls == CLS_BEYOND)
		|=> (out_valid_q && energy_q == '0 && !saturated_q))
		else $error("pair beyond cutoff gave a nonzero result");

	a_zero_dist_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && m4_vld && m4_tag_out.cls == CLS_ZERO)
		|=> (out_valid_q && saturated_q && energy_q == ENERGY_MAX))
		else $error("zero distance did not saturate");

endmodule

/* sv/lennard_jones_pair_energy.sv */
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy: 12-6 Lennard-Jones pair energy evaluator
// Per-type parameter tables, fixed-point energy with saturation.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid/in_ready) carries one request per
// accepted cycle. A request with mode 3 writes at most one table word
// (cutoff squared, sigma squared or epsilon of one type in one set) and
// gives no result. Every other request is a pair evaluation and gives
// exactly one result on the output channel (out_valid/out_ready), in
// request order. Throughput is one request per cycle, sustained while
// out_ready stays high. From acceptance a pair request passes through
// the table read, the request queue, the divider stages, a chain of
// four multipliers, the difference-term registers and the output register.
// A table word written by a load is seen by any pair request accepted after
// it. Reset clears all control state; the tables are not cleared and must
// be loaded before a pair type is used. When the receiver holds out_ready
// low, the back end freezes, a four-entry queue absorbs further requests,
// and in_ready falls only once that queue and the front stage are full.
// ----------------------------------------------------------------------------
module lennard_jones_pair_energy
	import ljpe_pkg::*;
#(
	parameter int PAIR_TYPES = 16,
	parameter int FRAC_BITS  = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 mode,
	input  logic [DATA_W-1:0]          distance_squared,
	input  logic [PAIR_TYPE_W-1:0]     pair_type,
	input  logic                       table_set,
	input  logic [1:0]                 word_select,
	input  logic [DATA_W-1:0]          load_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ENERGY_W-1:0] energy,
	output logic                       saturated
);

	// Front end output: a classified pair request with its table words.
	logic      fq_valid;
	logic      fq_ready;
	pair_req_t fq_req;

	// Queue output toward the arithmetic back end.
	logic      qb_valid;
	logic      qb_ready;
	pair_req_t qb_req;

	ljpe_front #(.PAIR_TYPES(PAIR_TYPES)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.distance_squared (distance_squared),
		.pair_type        (pair_type),
		.table_set        (table_set),
		.word_select      (word_select),
		.load_value       (load_value),
		.req_valid        (fq_valid),
		.req_ready        (fq_ready),
		.req              (fq_req)
	);

	// The queue decouples the table front end from the long arithmetic
	// pipeline, so a stalled receiver does not stop table loads at once.
	ljpe_queue #(.DEPTH(4)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_req),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_req)
	);

	ljpe_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (qb_valid),
		.req_ready (qb_ready),
		.req       (qb_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.energy    (energy),
		.saturated (saturated)
	);

endmodule

/* bench/tb_lennard_jones_pair_energy.sv */
// ----------------------------------------------------------------------------
// tb_lennard_jones_pair_energy: self-checking bench for the pair energy block
// A short table of directed requests covers the field extremes, every mode,
// table loads and the saturation cases. A long random stream follows, with
// table reloads. Each pair result is checked against a known result in its
// row or a bit-exact fixed-point energy predictor with its own tables.
// ----------------------------------------------------------------------------
module tb_lennard_jones_pair_energy
	import ljpe_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// The block is built with its default sizes. The bench relies on the
	// fraction width matching the block's FRAC_BITS.
	localparam int FRAC         = 24;
	localparam int RANDOM_ITEMS = 1330;
	// This margin covers the latency of a pair request.
	localparam int DRAIN_CYCLES = 100;

	// Load mode uses word selects 0 to 2. The fourth code writes nothing.
	localparam logic [1:0] WSEL_NONE = 2'd3;

	localparam logic [63:0] POS_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] ONE_FX    = 64'd1 << FRAC;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic                saturated;
	} energy_result_t;

	// One row of stimulus. When known is set, known_result is the energy
	// that can be read straight off the rules, and it is checked in place
	// of the predictor's answer.
	typedef struct packed {
		logic [1:0]             mode;
		logic [DATA_W-1:0]      dist_sq;
		logic [PAIR_TYPE_W-1:0] ptype;
		logic                   tset;
		logic [1:0]             wsel;
		logic [DATA_W-1:0]      word;
		logic                   known;
		energy_result_t         known_result;
	} request_row_t;

	localparam energy_result_t ZERO_ENERGY  = '{48'h0, 1'b0};
	localparam energy_result_t CLIPPED_HIGH = '{ENERGY_MAX, 1'b1};

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [1:0]                 mode;
	logic [DATA_W-1:0]          distance_squared;
	logic [PAIR_TYPE_W-1:0]     pair_type;
	logic                       table_set;
	logic [1:0]                 word_select;
	logic [DATA_W-1:0]          load_value;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [ENERGY_W-1:0] energy;
	logic                       saturated;

	// Bench copy of the three parameter tables. Slot = {set, pair type}.
	logic [DATA_W-1:0] cutoff_words  [32];
	logic [DATA_W-1:0] sigma_words   [32];
	logic [DATA_W-1:0] epsilon_words [32];

	// Energies owed by the block, oldest first.
	energy_result_t pending_energies [$];

	// The typed expectation of the request now on the bus, if any.
	logic           row_known = 1'b0;
	energy_result_t row_known_result = '0;

	int unsigned mismatch_count = 0;
	int unsigned burst_left = 0;

	lennard_jones_pair_energy u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.distance_squared (distance_squared),
		.pair_type        (pair_type),
		.table_set        (table_set),
		.word_select      (word_select),
		.load_value       (load_value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.energy           (energy),
		.saturated        (saturated)
	);

	// Directed requests. The first group sets up type 0 of the standard set
	// with the widest cutoff and unit sigma and epsilon, then tries a zero
	// distance, the potential minimum, the cutoff itself and the tiniest
	// nonzero distance, which overflows the powers. The unused word select
	// must leave the cutoff alone. Type 15 of the alternate set gets the
	// largest sigma and epsilon, so a pair at its cutoff clips high, and one
	// just past its cutoff gives zero. Type 7 first has a zero cutoff, where
	// a zero distance still counts as inside, then a wide cutoff with a zero
	// epsilon, where an overflowing pair gives zero without saturation.
	request_row_t directed_rows [25] = '{
		'{MODE_LOAD,   32'h0000_0000, 4'd0,  1'b0, WSEL_CUTOFF,  32'hFFFF_FFFF, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'hFFFF_FFFF, 4'd0,  1'b0, WSEL_SIGMA,   32'h0100_0000, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'h0000_0000, 4'd0,  1'b0, WSEL_EPSILON, 32'h0100_0000, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'h0000_0000, 4'd0,  1'b0, WSEL_NONE,    32'h0000_0000, 1'b0, ZERO_ENERGY},
		'{MODE_LJ,     32'h0000_0000, 4'd0,  1'b1, WSEL_NONE,    32'hFFFF_FFFF, 1'b1, CLIPPED_HIGH},
		'{MODE_WCA,    32'h0000_0000, 4'd0,  1'b0, WSEL_CUTOFF,  32'h0000_0000, 1'b1, CLIPPED_HIGH},
		'{MODE_LJ,     32'h0100_0000, 4'd0,  1'b1, WSEL_SIGMA,   32'h5A5A_5A5A, 1'b0, ZERO_ENERGY},
		'{MODE_WCA,    32'h0100_0000, 4'd0,  1'b0, WSEL_EPSILON, 32'hA5A5_A5A5, 1'b0, ZERO_ENERGY},
		'{MODE_LJ,     32'hFFFF_FFFF, 4'd0,  1'b1, WSEL_NONE,    32'hFFFF_FFFF, 1'b0, ZERO_ENERGY},
		'{MODE_WCA,    32'h0000_0001, 4'd0,  1'b0, WSEL_CUTOFF,  32'h0000_0000, 1'b0, ZERO_ENERGY},
		'{MODE_LJ,     32'h00E0_0000, 4'd0,  1'b1, WSEL_SIGMA,   32'h0F0F_0F0F, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'hFFFF_FFFF, 4'd15, 1'b1, WSEL_CUTOFF,  32'h0640_0000, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'h0000_0000, 4'd15, 1'b1, WSEL_SIGMA,   32'hFFFF_FFFF, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'hFFFF_FFFF, 4'd15, 1'b1, WSEL_EPSILON, 32'hFFFF_FFFF, 1'b0, ZERO_ENERGY},
		'{MODE_LJ_ALT, 32'h0640_0001, 4'd15, 1'b0, WSEL_NONE,    32'h0000_0000, 1'b1, ZERO_ENERGY},
		'{MODE_LJ_ALT, 32'h0640_0000, 4'd15, 1'b1, WSEL_CUTOFF,  32'hFFFF_FFFF, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'h0000_0000, 4'd7,  1'b0, WSEL_CUTOFF,  32'h0000_0000, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'h0000_0000, 4'd7,  1'b0, WSEL_SIGMA,   32'h0200_0000, 1'b0, ZERO_ENERGY},
		'{MODE_LOAD,   32'h0000_0000, 4'd7,  1'b0, WSEL_EPSILON, 32'h0000_0000, 1'b0, ZERO_ENERGY},
		'{MODE_WCA,    32'h0000_0000, 4'd7,  1'b1, WSEL_EPSILON, 32'hFFFF_FFFF, 1'b1, CLIPPED_HIGH},
		'{MODE_LJ,     32'h0000_0001, 4'd7,  1'b0, WSEL_NONE,    32'h0000_0000, 1'b1, ZERO_ENERGY},
		'{MODE_LOAD,   32'hFFFF_FFFF, 4'd7,  1'b0, WSEL_CUTOFF,  32'hFFFF_FFFF, 1'b0, ZERO_ENERGY},
		'{MODE_LJ,     32'h0000_0001, 4'd7,  1'b1, WSEL_SIGMA,   32'hFFFF_FFFF, 1'b1, ZERO_ENERGY},
		'{MODE_WCA,    32'h0200_0000, 4'd7,  1'b0, WSEL_CUTOFF,  32'h0000_0000, 1'b0, ZERO_ENERGY},
		'{MODE_LJ_ALT, 32'h0000_0000, 4'd15, 1'b1, WSEL_NONE,    32'hFFFF_FFFF, 1'b1, CLIPPED_HIGH}
	};

	// Fixed-point product: the full product shifted right by FRAC and
	// truncated. Bit 64 of the return value flags a result that does not
	// fit in 64 bits, in which case the low part is zero.
	function automatic logic [64:0] fixed_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] full;
		full = a * b;
		if (full[127:64+FRAC] != 0)
			return {1'b1, 64'd0};
		return {1'b0, full[FRAC +: 64]};
	endfunction

	// Energy of one pair request, from the bench copy of the tables.
	function automatic energy_result_t pair_energy_of(input logic [1:0] m,
			input logic [DATA_W-1:0] d2, input logic [PAIR_TYPE_W-1:0] pt);
		logic [4:0]     slot;
		logic [63:0]    cut, sig, eps, q, s2, s3, s6, dbl, pos, mag;
		logic [64:0]    pr;
		logic           ovf, neg;
		energy_result_t r;
		slot = {m == MODE_LJ_ALT, pt};
		cut = cutoff_words[slot];
		sig = sigma_words[slot];
		eps = epsilon_words[slot];
		r = ZERO_ENERGY;
		ovf = 1'b0;
		if (d2 > cut)
			return r;
		if (d2 == 0)
			return CLIPPED_HIGH;
		// s = sigma^2 / d^2, then s^2, s^3 and s^6 by truncating products.
		q = (sig << FRAC) / d2;
		pr = fixed_product(q, q);
		ovf |= pr[64];
		s2 = pr[63:0];
		pr = fixed_product(s2, q);
		ovf |= pr[64];
		s3 = pr[63:0];
		pr = fixed_product(s3, s3);
		ovf |= pr[64];
		s6 = pr[63:0];
		dbl = s3 << 1;
		ovf |= s3[63];
		pos = s6;
		if (m == MODE_WCA) begin
			pos = s6 + ONE_FX;
			ovf |= (pos < s6);
		end
		if (ovf) begin
			if (eps != 0)
				r = CLIPPED_HIGH;
			return r;
		end
		// Scale the magnitude by epsilon and put the sign back afterwards,
		// which rounds toward zero.
		neg = pos < dbl;
		mag = neg ? dbl - pos : pos - dbl;
		pr = fixed_product(eps, mag);
		if (!neg) begin
			if (pr[64] || pr[63:0] > POS_LIMIT)
				r = CLIPPED_HIGH;
			else
				r.energy = pr[ENERGY_W-1:0];
		end else if (pr[64] || pr[63:0] > POS_LIMIT + 1) begin
			r.energy = ENERGY_MIN;
			r.saturated = 1'b1;
		end else begin
			r.energy = -pr[ENERGY_W-1:0];
		end
		return r;
	endfunction

	// A table word for the given word select: mostly values in a physical
	// range, sometimes the extremes, sometimes anything at all.
	function automatic logic [DATA_W-1:0] random_word(input logic [1:0] wsel);
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return $urandom;
		case (wsel)
			WSEL_CUTOFF:  return pick == 1 ? 32'hFFFF_FFFF : $urandom_range(32'h1000_0000, 32'h0100_0000);
			WSEL_SIGMA:   return $urandom_range(32'h0400_0000, 32'h0040_0000);
			WSEL_EPSILON: return pick == 1 ? 32'h0 : $urandom_range(32'h0400_0000, 32'h0001_0000);
			default:      return $urandom;
		endcase
	endfunction

	// Puts one request on the input channel and returns at the falling edge
	// after it was accepted. Requests go out in bursts; between bursts the
	// valid line rests low for a few cycles. Valid is only ever changed at a
	// falling edge, so a request that follows straight on keeps it high.
	task automatic issue(input request_row_t r);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(10, 1)) @(negedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 50) : $urandom_range(16, 1);
		end
		mode = r.mode;
		distance_squared = r.dist_sq;
		pair_type = r.ptype;
		table_set = r.tset;
		word_select = r.wsel;
		load_value = r.word;
		row_known = r.known;
		row_known_result = r.known_result;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	// Holds the sender back until every owed energy has come out.
	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_energies.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Scoreboard. At each rising edge the result leaving the block is
	// compared first, then the accepted request, if any, is folded into the
	// bench state: a load updates the table copy, and a pair request queues
	// its expected energy. Doing both in one block keeps the order fixed.
	always @(posedge clk) begin : scoreboard
		energy_result_t want;
		energy_result_t predicted;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_energies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 40)
						$display("%0t: unexpected result, expected none, actual energy %h sat %b",
							$time, energy, saturated);
				end else begin
					want = pending_energies.pop_front();
					if (energy !== want.energy || saturated !== want.saturated) begin
						mismatch_count++;
						if (mismatch_count <= 40)
							$display("%0t: result mismatch, expected energy %h sat %b, actual energy %h sat %b",
								$time, want.energy, want.saturated, energy, saturated);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (mode == MODE_LOAD) begin
					case (word_select)
						WSEL_CUTOFF:  cutoff_words[{table_set, pair_type}] = load_value;
						WSEL_SIGMA:   sigma_words[{table_set, pair_type}] = load_value;
						WSEL_EPSILON: epsilon_words[{table_set, pair_type}] = load_value;
						default:      ;
					endcase
				end else begin
					predicted = pair_energy_of(mode, distance_squared, pair_type);
					pending_energies.push_back(row_known ? row_known_result : predicted);
				end
			end
		end
	end

	// The receiver alternates open windows and stalls.
	// Some windows are fully open, some take results only now and then.
	initial begin : receiver
		int unsigned open_left;
		int unsigned stall_left;
		int unsigned style;
		open_left = 0;
		stall_left = 0;
		style = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (open_left == 0 && stall_left == 0) begin
				style = $urandom_range(3);
				open_left = $urandom_range(style == 0 ? 300 : 30, 1);
				stall_left = $urandom_range(25);
			end
			if (stall_left != 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = (style == 2) ? 1'($urandom_range(1)) : 1'b1;
				open_left--;
			end
		end
	end

	// Stimulus: reset, the directed table, a full load of both table sets,
	// then random traffic with reloads mixed in.
	initial begin : stimulus
		request_row_t r;
		logic [4:0]   hot_slot;
		logic         follow_up;
		logic [4:0]   slot;
		logic [63:0]  lo, hi;
		int unsigned  pick;

		hot_slot = '0;
		follow_up = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_WCA;
		distance_squared = '0;
		pair_type = '0;
		table_set = 1'b0;
		word_select = WSEL_CUTOFF;
		load_value = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			issue(directed_rows[i]);
		drain_results();

		// Write all three words of every slot, so any pair request from here
		// on reads only written entries.
		for (int s = 0; s < 32; s++) begin
			for (int w = 0; w < 3; w++) begin
				r = '0;
				r.mode = MODE_LOAD;
				r.dist_sq = $urandom;
				r.tset = s[4];
				r.ptype = s[3:0];
				r.wsel = w[1:0];
				r.word = random_word(r.wsel);
				issue(r);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			r.dist_sq = $urandom;
			r.ptype = 4'($urandom_range(15));
			r.tset = 1'($urandom_range(1));
			r.wsel = 2'($urandom_range(3));
			r.word = $urandom;
			r.known = 1'b0;
			r.known_result = ZERO_ENERGY;
			if (follow_up) begin
				// A pair request right behind a load of the same slot checks
				// that the new word is already seen.
				r.ptype = hot_slot[3:0];
				r.mode = hot_slot[4] ? MODE_LJ_ALT : ($urandom_range(1) ? MODE_LJ : MODE_WCA);
				follow_up = 1'b0;
			end else if ($urandom_range(99) < 15) begin
				r.mode = MODE_LOAD;
				r.word = random_word(r.wsel);
				hot_slot = {r.tset, r.ptype};
				follow_up = 1'($urandom_range(1));
			end else begin
				r.mode = 2'($urandom_range(2));
			end
			if (r.mode != MODE_LOAD) begin
				// Distance: zero, anything, the cutoff itself, past the
				// cutoff, or most often near sigma where the curve bends.
				slot = {r.mode == MODE_LJ_ALT, r.ptype};
				pick = $urandom_range(15);
				if (pick == 0) begin
					r.dist_sq = '0;
				end else if (pick <= 2) begin
					r.dist_sq = $urandom;
				end else if (pick == 3) begin
					r.dist_sq = cutoff_words[slot];
				end else if (pick == 4 && cutoff_words[slot] != '1) begin
					r.dist_sq = $urandom_range(32'hFFFF_FFFF, cutoff_words[slot] + 1);
				end else begin
					lo = {32'd0, sigma_words[slot]} * 7 / 10;
					hi = {32'd0, sigma_words[slot]} * 3;
					if (hi > 64'hFFFF_FFFF)
						hi = 64'hFFFF_FFFF;
					if (lo == 0)
						lo = 1;
					r.dist_sq = $urandom_range(hi[31:0], lo[31:0]);
				end
			end
			issue(r);
		end

		drain_results();
		// Give a stray late result time to show up before the verdict.
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin : watchdog
		#1_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
